// ===== sv/rrbs_pkg.sv =====
// Package with shared constants and types of the round-robin budget scheduler.
`timescale 1ns / 1ps
package rrbs_pkg;
	localparam int NUM_TASKS = 16;
	localparam int ID_W = 4;
	localparam int CNT_W = 5;
	localparam int SLICE_W = 23;
	localparam int BUDGET_W = 24;
	localparam int PEND_W = 9;
	localparam int PENDING_MAX = 255;

	localparam logic [3:0] OP_CREATE = 4'd0;
	localparam logic [3:0] OP_ACTIVATE = 4'd1;
	localparam logic [3:0] OP_SCHEDULE = 4'd2;
	localparam logic [3:0] OP_DISPATCH = 4'd3;
	localparam logic [3:0] OP_EPILOGUE = 4'd4;
	localparam logic [3:0] OP_END_CYCLE = 4'd5;
	localparam logic [3:0] OP_UNBLOCK = 4'd6;
	localparam logic [3:0] OP_END = 4'd7;
	localparam logic [3:0] OP_TIMER = 4'd8;

	localparam logic [1:0] ST_SLEEP = 2'd0;
	localparam logic [1:0] ST_READY = 2'd1;
	localparam logic [1:0] ST_IDLE = 2'd2;
	localparam logic [1:0] ST_OUT = 2'd3;

	localparam logic CFG_DEFAULT_SLICE = 1'b0;
	localparam logic CFG_ACCEPTED = 1'b1;

	typedef struct packed {
		logic [3:0] operation;
		logic [3:0] task_id;
		logic [1:0] task_class;
		logic [22:0] own_slice;
		logic keep_arrivals;
		logic is_periodic;
		logic [22:0] consumed_time;
	} req_t;

	typedef struct packed {
		logic status_code;
		logic [3:0] selected_task;
		logic none_ready;
		logic reschedule_needed;
		logic start_period_timer;
	} rsp_t;
endpackage

// ===== sv/rrbs_if.sv =====
// Valid/ready channel interfaces for the request and the response word.
`timescale 1ns / 1ps
interface rrbs_req_if;
	import rrbs_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rrbs_rsp_if;
	import rrbs_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/round_robin_budget_scheduler.sv =====
// Top level of the round-robin budget scheduler.
//
// One request word enters on req (valid/ready) and exactly one response word
// leaves on rsp. The block works on one word at a time: req.ready is high only
// when the sequencer is idle and no response is waiting.
// Queue edits go through a single shifter that moves one queue slot a cycle;
// a schedule rotates exhausted head tasks to the tail, at most as many of
// them as the queue length.
// Configuration registers are written on cfg_we / cfg_index / cfg_data.
// The user must write them only while the block is idle; it is not enforced.
// Reset clears the queue length, task states, periodic flags and sets every
// pending count to "not saved"; no clearing pass is needed.
// When the receiver stalls, the response is held in its output register and
// no new word is taken until it has been delivered.
`timescale 1ns / 1ps
module round_robin_budget_scheduler
	import rrbs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [22:0] cfg_data,
	rrbs_req_if.sink req,
	rrbs_rsp_if.source rsp
);
	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_FIND, S_SHIFT_L, S_INS, S_SHIFT_R, S_SCHED, S_DONE
	} state_t;

	state_t state_q;
	logic [22:0] dslice_q;
	logic [2:0] accept_q;
	req_t req_q;
	rsp_t rsp_q;
	logic rsp_valid_q;

	logic [ID_W-1:0] order_q [NUM_TASKS];
	logic [CNT_W-1:0] count_q;
	logic [1:0] tstate_q [NUM_TASKS];
	logic [BUDGET_W-1:0] budget_q [NUM_TASKS];
	logic [SLICE_W-1:0] slice_q [NUM_TASKS];
	logic [PEND_W-1:0] pend_q [NUM_TASKS];
	logic [NUM_TASKS-1:0] per_q;

	// Queue edit sequencer: target id, scan index, insert mode.
	logic [ID_W-1:0] qid_q;
	logic [CNT_W-1:0] idx_q;
	logic ins_q;     // insert after remove
	logic head_q;    // insert at head
	logic sched_q;   // edit belongs to a schedule rotation
	logic [CNT_W-1:0] turns_q;

	logic [ID_W-1:0] head_id;
	logic signed [BUDGET_W:0] sub_w;
	logic [BUDGET_W-1:0] sat_w;
	logic [ID_W-1:0] tid;
	logic [PEND_W-1:0] pcur;

	assign tid = req_q.task_id;
	assign head_id = order_q[0];
	assign pcur = pend_q[tid];
	assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	// Saturating budget subtraction for epilogue.
	always_comb begin
		sub_w = $signed({budget_q[tid][BUDGET_W-1], budget_q[tid]})
			- $signed({2'b00, req_q.consumed_time});
		if (sub_w < -$signed(25'sd8388608))
			sat_w = 24'h800000;
		else
			sat_w = sub_w[BUDGET_W-1:0];
	end

	// Sequencer with all state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dslice_q <= 23'd1000;
			accept_q <= 3'd1;
			rsp_valid_q <= 1'b0;
			count_q <= '0;
			per_q <= '0;
			for (int i = 0; i < NUM_TASKS; i++) begin
				tstate_q[i] <= ST_SLEEP;
				pend_q[i] <= '1;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_DEFAULT_SLICE)
					dslice_q <= cfg_data;
				else
					accept_q <= cfg_data[2:0];
			end
			if (rsp_valid_q && rsp.ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						req_q <= req.data;
						rsp_q <= '0;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					qid_q <= tid;
					idx_q <= '0;
					ins_q <= 1'b0;
					head_q <= 1'b0;
					sched_q <= 1'b0;
					state_q <= S_DONE;
					case (req_q.operation)
						OP_SCHEDULE: begin
							turns_q <= count_q;
							if (count_q == '0)
								rsp_q.none_ready <= 1'b1;
							else
								state_q <= S_SCHED;
						end
						OP_CREATE: begin
							if (req_q.task_class == 2'd3 || !accept_q[req_q.task_class]) begin
								rsp_q.status_code <= 1'b1;
							end else begin
								tstate_q[tid] <= ST_SLEEP;
								if (req_q.task_class == 2'd0) begin
									slice_q[tid] <= (req_q.own_slice != '0) ?
										req_q.own_slice : dslice_q;
									budget_q[tid] <= {1'b0, (req_q.own_slice != '0) ?
										req_q.own_slice : dslice_q};
									pend_q[tid] <= req_q.keep_arrivals ? '0 : '1;
									per_q[tid] <= 1'b0;
								end else begin
									slice_q[tid] <= dslice_q;
									budget_q[tid] <= {1'b0, dslice_q};
									pend_q[tid] <= (req_q.task_class == 2'd2 ||
										req_q.keep_arrivals) ? '0 : '1;
									per_q[tid] <= req_q.is_periodic;
								end
								state_q <= S_FIND;
							end
						end
						OP_ACTIVATE: begin
							if (tstate_q[tid] != ST_SLEEP && tstate_q[tid] != ST_IDLE) begin
								if (!pcur[PEND_W-1] && pcur < PEND_W'(PENDING_MAX))
									pend_q[tid] <= pcur + 1'b1;
							end else begin
								tstate_q[tid] <= ST_READY;
								rsp_q.start_period_timer <= per_q[tid];
								ins_q <= 1'b1;
								state_q <= S_FIND;
							end
						end
						OP_DISPATCH: begin
							tstate_q[tid] <= ST_OUT;
							state_q <= S_FIND;
						end
						OP_EPILOGUE: begin
							tstate_q[tid] <= ST_READY;
							ins_q <= 1'b1;
							if ($signed(sat_w) <= 0) begin
								budget_q[tid] <= sat_w + {1'b0, slice_q[tid]};
							end else begin
								budget_q[tid] <= sat_w;
								head_q <= 1'b1;
							end
							state_q <= S_FIND;
						end
						OP_END_CYCLE: begin
							if (!pcur[PEND_W-1] && pcur != '0) begin
								pend_q[tid] <= pcur - 1'b1;
								tstate_q[tid] <= ST_READY;
								ins_q <= 1'b1;
								head_q <= 1'b1;
							end else begin
								tstate_q[tid] <= ST_IDLE;
							end
							state_q <= S_FIND;
						end
						OP_UNBLOCK: begin
							tstate_q[tid] <= ST_READY;
							ins_q <= 1'b1;
							state_q <= S_FIND;
						end
						OP_END: begin
							pend_q[tid] <= '1;
							tstate_q[tid] <= ST_OUT;
							state_q <= S_FIND;
						end
						OP_TIMER: begin
							if (tstate_q[tid] == ST_IDLE) begin
								tstate_q[tid] <= ST_READY;
								rsp_q.reschedule_needed <= 1'b1;
								ins_q <= 1'b1;
								state_q <= S_FIND;
							end else if (!pcur[PEND_W-1] && pcur < PEND_W'(PENDING_MAX)) begin
								pend_q[tid] <= pcur + 1'b1;
							end
						end
						default: ;
					endcase
				end
				// Schedule: refill and rotate an exhausted head to tail, else select head.
				S_SCHED: begin
					if (turns_q != '0 && $signed(budget_q[head_id]) <= 0) begin
						budget_q[head_id] <= budget_q[head_id] + {1'b0, slice_q[head_id]};
						turns_q <= turns_q - 1'b1;
						qid_q <= head_id;
						idx_q <= '0;
						ins_q <= 1'b1;
						head_q <= 1'b0;
						sched_q <= 1'b1;
						state_q <= S_FIND;
					end else begin
						rsp_q.selected_task <= head_id;
						state_q <= S_DONE;
					end
				end
				// Scan for the entry of qid_q, one slot a cycle.
				S_FIND: begin
					if (idx_q >= count_q)
						state_q <= S_INS;
					else if (order_q[idx_q[ID_W-1:0]] == qid_q)
						state_q <= S_SHIFT_L;
					else
						idx_q <= idx_q + 1'b1;
				end
				// Close the gap left by the removed entry.
				S_SHIFT_L: begin
					if (idx_q + 1'b1 < count_q) begin
						order_q[idx_q[ID_W-1:0]] <= order_q[idx_q[ID_W-1:0] + 1'b1];
						idx_q <= idx_q + 1'b1;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= S_INS;
					end
				end
				S_INS: begin
					if (!ins_q)
						state_q <= sched_q ? S_SCHED : S_DONE;
					else if (!head_q) begin
						order_q[count_q[ID_W-1:0]] <= qid_q;
						count_q <= count_q + 1'b1;
						state_q <= sched_q ? S_SCHED : S_DONE;
					end else begin
						idx_q <= count_q;
						state_q <= S_SHIFT_R;
					end
				end
				// Open a slot at the head.
				S_SHIFT_R: begin
					if (idx_q != '0) begin
						order_q[idx_q[ID_W-1:0]] <= order_q[idx_q[ID_W-1:0] - 1'b1];
						idx_q <= idx_q - 1'b1;
					end else begin
						order_q[0] <= qid_q;
						count_q <= count_q + 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					rsp_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
